// ===== hw/rtl/rgba_delta_pixel_reconstruct_assert.svh =====
// assertion macros shared by the pixel reconstruction rtl
`ifndef RGBA_DELTA_PIXEL_RECONSTRUCT_ASSERT_SVH
`define RGBA_DELTA_PIXEL_RECONSTRUCT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define RDPR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// next-cycle implication, checked out of reset
`define RDPR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define RDPR_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RDPR_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/rgbadr_pkg.sv =====
// types, constants and helpers for the pixel reconstruction block
`timescale 1ns / 1ps

package rgbadr_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 13;
    localparam int HEIGHT_W  = 16;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 4 * CHAN_W;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_ALPHA_ENABLED = 2'd2;

    // pixel word as held in the row store
    typedef struct packed {
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] r;
    } rgba_t;

    // per-channel modulo-256 add
    function automatic rgba_t add_bytes(input rgba_t x, input rgba_t y);
        rgba_t s;
        s.r = x.r + y.r;
        s.g = x.g + y.g;
        s.b = x.b + y.b;
        s.a = x.a + y.a;
        return s;
    endfunction

endpackage

// ===== hw/rtl/rgbadr_in_if.sv =====
// input pixel channel: residual bytes with valid/ready
`timescale 1ns / 1ps

interface rgbadr_in_if
    import rgbadr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] blue_residual;
    logic [CHAN_W-1:0] green_residual;
    logic [CHAN_W-1:0] red_residual;
    logic [CHAN_W-1:0] alpha_residual;

    modport source (
        output valid, blue_residual, green_residual, red_residual, alpha_residual,
        input  ready
    );
    modport sink (
        input  valid, blue_residual, green_residual, red_residual, alpha_residual,
        output ready
    );
endinterface

// ===== hw/rtl/rgbadr_out_if.sv =====
// output pixel channel: reconstructed rgba plus framing flags
`timescale 1ns / 1ps

interface rgbadr_out_if
    import rgbadr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              end_of_row;
    logic              end_of_image;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, end_of_row, end_of_image,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, end_of_row, end_of_image,
        output ready
    );
endinterface

// ===== hw/rtl/rgbadr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module rgbadr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/rgba_delta_pixel_reconstruct.sv =====
// top level: delta reconstruction of an rgba raster stream
`timescale 1ns / 1ps
`include "rgba_delta_pixel_reconstruct_assert.svh"

// usage
// - in_pix carries one pixel per transaction in raster order as residual bytes;
//   out_pix returns one reconstructed rgba pixel per input transaction, in order,
//   flagged with end_of_row and end_of_image
// - apb port: frame width at 0x0, frame height at 0x4, alpha enable at 0x8;
//   write only while the block is idle; pready is always high
// - path: an accepted pixel waits in the middle stage for the registered read of the row
//   store, then sits in the output register that drives out_pix
// - throughput: one pixel per cycle unless out_pix stalls, set by the single row
//   store ram, read when a pixel is accepted and written as it leaves the middle stage
// - a write and a read of the same column in one cycle are resolved by a
//   forwarding register, so narrow images keep the full rate
// - reset clears the counters, the running sums, the pipeline and the registers
//   (width 1, height 1, alpha off); the row store is not cleared and needs none,
//   as the first row of every image never uses what it reads there
// - when out_pix stalls, the output register holds its transaction; the middle
//   stage still drains into a free output register and in_pix.ready drops only
//   once both are occupied
module rgba_delta_pixel_reconstruct
    import rgbadr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rgbadr_in_if.sink          in_pix,
    rgbadr_out_if.source       out_pix
);

    // middle stage: pixel waiting for its row-above word
    typedef struct packed {
        rgba_t             sum;
        logic [COL_W-1:0]  col;
        logic              has_above;
        logic              alpha_en;
        logic              eor;
        logic              eoi;
    } stage_t;

    // configuration registers
    logic [WIDTH_W-1:0]  width_reg,  width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic                alpha_reg,  alpha_next;

    // stream state
    logic [COL_W-1:0]    col_idx_reg, col_idx_next;
    logic [HEIGHT_W-1:0] row_idx_reg, row_idx_next;
    rgba_t               sums_reg,    sums_next;

    // pipeline
    logic   s1_valid_reg,  s1_valid_next;
    stage_t s1_reg,        s1_next;
    logic   fwd_hit_reg,   fwd_hit_next;
    rgba_t  fwd_data_reg,  fwd_data_next;
    logic   out_valid_reg, out_valid_next;
    rgba_t  out_pix_reg,   out_pix_next;
    logic   out_eor_reg,   out_eor_next;
    logic   out_eoi_reg,   out_eoi_next;

    // combinational
    logic                apb_wr;
    logic                accept;
    logic                s1_advance;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    col_clamped;
    logic                eor_c;
    logic                eoi_c;
    rgba_t               delta;
    rgba_t               sum_c;
    rgba_t               above_raw;
    rgba_t               above;
    rgba_t               pix_c;
    logic                ram_we;
    rgba_t               ram_rdata;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        alpha_next  = alpha_reg;
        if (apb_wr)
        begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:   width_next  = pwdata[WIDTH_W-1:0];
                REG_FRAME_HEIGHT:  height_next = pwdata[HEIGHT_W-1:0];
                REG_ALPHA_ENABLED: alpha_next  = pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:   prdata = {{(PDATA_W-WIDTH_W){1'b0}}, width_reg};
            REG_FRAME_HEIGHT:  prdata = {{(PDATA_W-HEIGHT_W){1'b0}}, height_reg};
            REG_ALPHA_ENABLED: prdata = {{(PDATA_W-1){1'b0}}, alpha_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- handshake
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || out_pix.ready);
    assign in_pix.ready = !s1_valid_reg || s1_advance;
    assign accept       = in_pix.valid && in_pix.ready;

    // ------------------------------------------------- accept-side logic
    // zero width reads as one, anything past the store depth as the depth
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    // a column left past the edge by a width change sits on the last column
    assign col_clamped = ({1'b0, col_idx_reg} >= w_eff) ? COL_W'(w_eff - WIDTH_W'(1))
                                                        : col_idx_reg;
    assign eor_c = ({1'b0, col_idx_reg} + WIDTH_W'(1)) >= w_eff;
    assign eoi_c = eor_c && (({1'b0, row_idx_reg} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff});

    // green goes into red and blue before the horizontal sum
    always_comb
    begin
        delta.r = in_pix.red_residual  + in_pix.green_residual;
        delta.g = in_pix.green_residual;
        delta.b = in_pix.blue_residual + in_pix.green_residual;
        delta.a = alpha_reg ? in_pix.alpha_residual : '0;
    end

    assign sum_c = add_bytes(sums_reg, delta);

    always_comb
    begin
        col_idx_next = col_idx_reg;
        row_idx_next = row_idx_reg;
        sums_next    = sums_reg;
        if (accept)
        begin
            if (eor_c)
            begin
                col_idx_next = '0;
                sums_next    = '0;
                row_idx_next = eoi_c ? '0 : row_idx_reg + HEIGHT_W'(1);
            end
            else
            begin
                col_idx_next = col_idx_reg + COL_W'(1);
                sums_next    = sum_c;
            end
        end
    end

    // ------------------------------------------------------ middle stage
    // word written in the cycle of our read came too late for the ram
    assign above_raw = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign above     = s1_reg.has_above ? above_raw : '0;

    always_comb
    begin
        pix_c = add_bytes(s1_reg.sum, above);
        if (!s1_reg.alpha_en)
        begin
            pix_c.a = ALPHA_OPAQUE;
        end
    end

    assign ram_we = s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        fwd_hit_next  = fwd_hit_reg;
        fwd_data_next = fwd_data_reg;
        if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next       = 1'b1;
            s1_next.sum         = sum_c;
            s1_next.col         = col_clamped;
            s1_next.has_above   = (row_idx_reg != '0);
            s1_next.alpha_en    = alpha_reg;
            s1_next.eor         = eor_c;
            s1_next.eoi         = eoi_c;
            fwd_hit_next        = ram_we && (s1_reg.col == col_clamped);
            fwd_data_next       = pix_c;
        end
    end

    rgbadr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_reg.col),
        .wdata (pix_c),
        .re    (accept),
        .raddr (col_clamped),
        .rdata (ram_rdata)
    );

    // ----------------------------------------------------- output stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_eor_next   = out_eor_reg;
        out_eoi_next   = out_eoi_reg;
        if (out_valid_reg && out_pix.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = pix_c;
            out_eor_next   = s1_reg.eor;
            out_eoi_next   = s1_reg.eoi;
        end
    end

    assign out_pix.valid        = out_valid_reg;
    assign out_pix.red_out      = out_pix_reg.r;
    assign out_pix.green_out    = out_pix_reg.g;
    assign out_pix.blue_out     = out_pix_reg.b;
    assign out_pix.alpha_out    = out_pix_reg.a;
    assign out_pix.end_of_row   = out_eor_reg;
    assign out_pix.end_of_image = out_eoi_reg;

    // ---------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_W'(1);
            height_reg    <= HEIGHT_W'(1);
            alpha_reg     <= 1'b0;
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
            sums_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            alpha_reg     <= alpha_next;
            col_idx_reg   <= col_idx_next;
            row_idx_reg   <= row_idx_next;
            sums_reg      <= sums_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        fwd_data_reg <= fwd_data_next;
        out_pix_reg  <= out_pix_next;
        out_eor_reg  <= out_eor_next;
        out_eoi_reg  <= out_eoi_next;
    end

    // --------------------------------------------------------- assertions
    `RDPR_ASSERT_NXT(a_row_end_clears_sums, clk, rst_n, accept && eor_c, sums_reg == '0)
    `RDPR_ASSERT_NXT(a_image_end_rewinds, clk, rst_n, accept && eoi_c,
                     col_idx_reg == '0 && row_idx_reg == '0)
    `RDPR_ASSERT_IMP(a_write_only_from_stage, clk, rst_n, !s1_valid_reg, !ram_we)
    `RDPR_ASSERT_NXT(a_accept_fills_stage, clk, rst_n, accept, s1_valid_reg)
    `RDPR_ASSERT_IMP(a_eoi_needs_eor, clk, rst_n, s1_valid_reg && s1_reg.eoi, s1_reg.eor)

endmodule
